// ----- rtl/bounded_array_list_with_insert_macros.svh -----
// Assertion macros used by the assertion checker of the bounded array list.
`ifndef BOUNDED_ARRAY_LIST_WITH_INSERT_MACROS_SVH
`define BOUNDED_ARRAY_LIST_WITH_INSERT_MACROS_SVH

// Checked on every rising edge of aclk while aresetn is high.
`define BALWI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define BALWI_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/balwi_pkg.sv -----
// Shared types, codes and field widths of the bounded array list.
package balwi_pkg;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - (STATUS_W + VALUE_W + COUNT_W);

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_SET    = 2'd1,
        OP_INSERT = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic latch_req;
        logic set_status;
        logic capture_rd;
        logic wr_append;
        logic wr_pos;
        logic wr_shift;
        logic rd_shift;
        logic inc_count;
        logic load_idx;
        logic dec_idx;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic at_end;
        logic shift_done;
    } sts_t;

endpackage

// ----- rtl/balwi_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module balwi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/balwi_dp.sv -----
// Datapath of the bounded array list: request, count, entry memory and result registers.
module balwi_dp #(
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [balwi_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic [balwi_pkg::OPCODE_W-1:0]   in_opcode,
    input  logic [balwi_pkg::POS_W-1:0]      in_position,
    input  logic [balwi_pkg::VALUE_W-1:0]    in_item_value,
    input  balwi_pkg::cmd_t                  cmd,
    output balwi_pkg::sts_t                  sts,
    output balwi_pkg::status_t               out_status,
    output logic [balwi_pkg::VALUE_W-1:0]    out_read_value,
    output logic [balwi_pkg::COUNT_W-1:0]    out_entry_count
);

    import balwi_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    op_t                op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [CW-1:0]      count_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [AW-1:0]      idx_reg;
    status_t            status_reg;
    logic [VALUE_W-1:0] rd_reg;
    status_t            out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [LW-1:0]      cap_ext;
    logic [LW-1:0]      limit;
    logic [LW-1:0]      cnt_ext;
    logic [LW-1:0]      pos_ext;
    logic               full;
    logic               range_err;
    logic               full_err;
    status_t            status_code;
    logic [AW-1:0]      pos_addr;
    logic [AW-1:0]      pos_plus1;
    logic [AW-1:0]      idx_minus1;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;

    assign cap_ext    = LW'(cap_reg);
    assign limit      = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    assign cnt_ext    = LW'(count_reg);
    assign pos_ext    = LW'(pos_reg);
    assign full       = (cnt_ext >= limit);
    assign pos_addr   = AW'(pos_reg);
    assign pos_plus1  = pos_addr + AW'(1);
    assign idx_minus1 = idx_reg - AW'(1);

    always_comb begin
        range_err = 1'b0;
        full_err  = 1'b0;
        case (op_reg)
            OP_APPEND: begin
                full_err = full;
            end
            OP_INSERT: begin
                range_err = (pos_ext > cnt_ext);
                full_err  = full;
            end
            OP_SET, OP_GET: begin
                range_err = (pos_ext >= cnt_ext);
            end
            default: begin
                range_err = 1'b0;
            end
        endcase
        if (range_err) begin
            status_code = STAT_RANGE;
        end else if (full_err) begin
            status_code = STAT_FULL;
        end else begin
            status_code = STAT_OK;
        end
    end

    assign sts.op         = op_reg;
    assign sts.err        = range_err || full_err;
    assign sts.at_end     = (pos_ext == cnt_ext);
    assign sts.shift_done = (idx_reg == pos_plus1);

    always_comb begin
        ram_we    = cmd.wr_append || cmd.wr_pos || cmd.wr_shift;
        ram_waddr = pos_addr;
        ram_wdata = val_reg;
        if (cmd.wr_append) begin
            ram_waddr = AW'(count_reg);
        end else if (cmd.wr_shift) begin
            ram_waddr = idx_reg;
            ram_wdata = ram_rdata;
        end
        ram_raddr = cmd.rd_shift ? idx_minus1 : pos_addr;
    end

    balwi_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.inc_count) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            op_reg  <= op_t'(in_opcode);
            pos_reg <= in_position;
            val_reg <= in_item_value;
        end
        if (cmd.set_status) begin
            status_reg <= status_code;
            rd_reg     <= '0;
        end else if (cmd.capture_rd) begin
            rd_reg <= ram_rdata;
        end
        if (cmd.load_idx) begin
            idx_reg <= AW'(count_reg);
        end else if (cmd.dec_idx) begin
            idx_reg <= idx_minus1;
        end
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_value_reg  <= rd_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    assign out_status      = out_status_reg;
    assign out_read_value  = out_value_reg;
    assign out_entry_count = out_count_reg;

endmodule

// ----- rtl/balwi_ctrl.sv -----
// Controller state machine of the bounded array list and its result handshake.
module balwi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  balwi_pkg::sts_t sts,
    output balwi_pkg::cmd_t cmd
);

    import balwi_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_EXEC     = 7'b0000010,
        ST_RD_WAIT  = 7'b0000100,
        ST_SHIFT_RD = 7'b0001000,
        ST_SHIFT_WR = 7'b0010000,
        ST_INS_WR   = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.set_status = 1'b1;
                state_next     = ST_FINISH;
                if (!sts.err) begin
                    case (sts.op)
                        OP_APPEND: begin
                            cmd.wr_append = 1'b1;
                            cmd.inc_count = 1'b1;
                        end
                        OP_SET, OP_GET: begin
                            state_next = ST_RD_WAIT;
                        end
                        OP_INSERT: begin
                            if (sts.at_end) begin
                                cmd.wr_pos    = 1'b1;
                                cmd.inc_count = 1'b1;
                            end else begin
                                cmd.load_idx = 1'b1;
                                state_next   = ST_SHIFT_RD;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                cmd.capture_rd = 1'b1;
                cmd.wr_pos     = (sts.op == OP_SET);
                state_next     = ST_FINISH;
            end
            ST_SHIFT_RD: begin
                cmd.rd_shift = 1'b1;
                state_next   = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                if (sts.shift_done) begin
                    state_next = ST_INS_WR;
                end else begin
                    cmd.dec_idx = 1'b1;
                    state_next  = ST_SHIFT_RD;
                end
            end
            ST_INS_WR: begin
                cmd.wr_pos    = 1'b1;
                cmd.inc_count = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ----- rtl/bounded_array_list_with_insert.sv -----
// Top level of the bounded array list with append, set, insert and get.
// The block keeps an ordered list of up to DEPTH signed 32-bit words in a RAM
// and answers every request transaction with one result transaction carrying
// a status, a read value and the entry count after the request. It works on
// one request at a time: an append, a rejected request or an insert at the
// count goes from execute straight to finish, a set or get passes a read
// wait state, and an insert below the count passes a shift read and a shift
// write state for each entry from the position onward, because each such
// entry is moved by one read and one write through the single RAM port pair.
// A finished result sits in an output register, so the next request is
// accepted while it waits. The capacity register limits the list to
// min(capacity, DEPTH) entries; it resets to 16 and may be written while idle.
// The entry memory is not cleared at reset; only entries below the count are
// ever read.
module bounded_array_list_with_insert #(
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [balwi_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode [1:0], position [6:2], item_value [38:7], zero [39]
    input  logic [balwi_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status [1:0], read_value [33:2], entry_count [38:34], zero [39]
    output logic [balwi_pkg::M_TDATA_W-1:0]  m_tdata
);

    import balwi_pkg::*;

    logic [OPCODE_W-1:0] in_opcode;
    logic [POS_W-1:0]    in_position;
    logic [VALUE_W-1:0]  in_item_value;
    cmd_t                cmd;
    sts_t                sts;
    status_t             out_status;
    logic [VALUE_W-1:0]  out_read_value;
    logic [COUNT_W-1:0]  out_entry_count;

    assign in_opcode     = s_tdata[OPCODE_W-1:0];
    assign in_position   = s_tdata[OPCODE_W +: POS_W];
    assign in_item_value = s_tdata[OPCODE_W + POS_W +: VALUE_W];

    balwi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    balwi_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_opcode       (in_opcode),
        .in_position     (in_position),
        .in_item_value   (in_item_value),
        .cmd             (cmd),
        .sts             (sts),
        .out_status      (out_status),
        .out_read_value  (out_read_value),
        .out_entry_count (out_entry_count)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_entry_count, out_read_value, out_status};

endmodule

// ----- rtl/balwi_checker.sv -----
// Port-level assertion checker for the bounded array list and its bind statement.
module balwi_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [balwi_pkg::M_TDATA_W-1:0]  m_tdata
);

    import balwi_pkg::*;

    `include "bounded_array_list_with_insert_macros.svh"

    logic               m_stalled;
    logic               m_rejected;
    logic [VALUE_W-1:0] m_read_value;

    assign m_stalled    = m_tvalid && !m_tready;
    assign m_rejected   = m_tvalid && (m_tdata[STATUS_W-1:0] != STAT_OK);
    assign m_read_value = m_tdata[STATUS_W +: VALUE_W];

    `BALWI_ASSERT_ANY(a_no_result_after_reset, !aresetn |=> !m_tvalid, "result after reset")

    `BALWI_ASSERT_RST(a_result_held, m_stalled |=> m_tvalid && $stable(m_tdata), "held result changed")

    `BALWI_ASSERT_RST(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    `BALWI_ASSERT_RST(a_reject_reads_zero, m_rejected |-> m_read_value == '0, "nonzero read value")

endmodule

bind bounded_array_list_with_insert balwi_checker u_checker (.*);
